// ===== src/rope_pkg.sv =====
// Shared types and constants of the rotary position embedding block.
package rope_pkg;

	// Width of the element counter and of the dimension registers.
	localparam int CNT_W = 9;
	// Width of an element index on the result channel.
	localparam int POS_W = 8;
	// Width of the cosine and sine coefficients.
	localparam int COEF_BITS = 16;

	// Configuration port layout.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] CFG_PAIR_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTARY_DIMS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAD_DIMS = 2'd2;

	// Values of the dimension registers after reset.
	localparam logic [CNT_W-1:0] DIMS_RESET = 9'd64;

	// Pairing modes.
	localparam logic MODE_HALF = 1'b0;
	localparam logic MODE_INTERLEAVE = 1'b1;

	// Result queue geometry.
	localparam int OUT_DEPTH = 8;
	localparam int OUT_PTR_W = 3;
	localparam int OUT_CNT_W = 4;

	// What an accepted element does.
	typedef enum logic [1:0] {
		KIND_PASS,
		KIND_HOLD,
		KIND_PAIR
	} item_kind_t;

endpackage

// ===== src/rotary_position_embedding_top.sv =====
// Rotary position embedding over a stream of head-vector elements.
//
// Elements enter on the input channel (in_valid/in_ready) with x_value and
// the cosine and sine coefficients of their position, one transaction per
// element. Results leave on the output channel (out_valid/out_ready), one
// transaction per result, carrying the element index, the value and a flag
// on the last result of the head vector. Registers are written through the
// cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data); the user must write
// them only while the block is idle, which the block itself does not enforce.
// cfg_ready is always high. Throughput is one element per cycle, while the
// receiver takes results, for pass-through elements and in interleave mode.
// In half mode each element of the second half gives two results, and the
// single output port takes one per cycle, so those elements cannot be taken
// every cycle. A result is registered in stage 1 (hold memory read) and in
// stage 2 (multiply), then rounded into the result queue before it is offered.
// An eight-entry result queue decouples the two sides; when the receiver
// stalls the queue fills and in_ready drops once no room is left for the
// results still in flight. Reset returns the registers to half mode with
// 64 rotated and 64 total dimensions, clears the element counter and
// empties the queue; the hold memory keeps whatever it held.
module rotary_position_embedding_top #(
	parameter int MAX_HEAD = 256,
	parameter int DATA_BITS = 16,
	parameter int COEF_FRAC = 14
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [rope_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [rope_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [DATA_BITS-1:0]            x_value,
	input  logic signed [rope_pkg::COEF_BITS-1:0]  cos_coef,
	input  logic signed [rope_pkg::COEF_BITS-1:0]  sin_coef,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [rope_pkg::POS_W-1:0]             out_position,
	output logic signed [DATA_BITS-1:0]            out_value,
	output logic                                   vector_end
);
	import rope_pkg::*;

	// The hold memory covers the first half of the widest rotated part.
	localparam int HOLD_DEPTH = (MAX_HEAD / 2 > 0) ? MAX_HEAD / 2 : 1;
	localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
	// Largest head width that the 9-bit register can reach.
	localparam int HEAD_LIM = (MAX_HEAD > 511) ? 511 : MAX_HEAD;
	localparam logic [CNT_W-1:0] HEAD_LIM_C = CNT_W'(HEAD_LIM);
	// Product and sum widths, and the width of the rounded quotient.
	localparam int PW = DATA_BITS + COEF_BITS;
	localparam int SW = PW + 1;
	localparam int QW = ((SW - COEF_FRAC + 1) > (DATA_BITS + 1)) ?
		(SW - COEF_FRAC + 1) : (DATA_BITS + 1);
	localparam logic signed [QW-1:0] SAT_HI =
		{{(QW - DATA_BITS + 1){1'b0}}, {(DATA_BITS - 1){1'b1}}};
	localparam logic signed [QW-1:0] SAT_LO =
		{{(QW - DATA_BITS + 1){1'b1}}, {(DATA_BITS - 1){1'b0}}};

	typedef struct packed {
		logic signed [DATA_BITS-1:0] xv;
		logic signed [COEF_BITS-1:0] cosv;
		logic signed [COEF_BITS-1:0] sinv;
	} hold_entry_t;

	typedef struct packed {
		logic [POS_W-1:0]            pos;
		logic signed [DATA_BITS-1:0] value;
		logic                        last;
	} result_t;

	// Round to nearest with ties to even, then saturate to DATA_BITS.
	function automatic logic signed [DATA_BITS-1:0] round_sat(input logic signed [SW-1:0] v);
		logic signed [QW-1:0]  q;
		logic [COEF_FRAC-1:0]  r;
		logic                  up;
		logic signed [DATA_BITS-1:0] res;
		q = QW'(v >>> COEF_FRAC);
		r = v[COEF_FRAC-1:0];
		up = r[COEF_FRAC-1] && ((r[COEF_FRAC-2:0] != '0) || q[0]);
		q = q + $signed({{(QW - 1){1'b0}}, up});
		if (q > SAT_HI) begin
			res = SAT_HI[DATA_BITS-1:0];
		end else if (q < SAT_LO) begin
			res = SAT_LO[DATA_BITS-1:0];
		end else begin
			res = q[DATA_BITS-1:0];
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic             pair_mode_q;
	logic [CNT_W-1:0] rotary_dims_q;
	logic [CNT_W-1:0] head_dims_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_mode_q <= MODE_HALF;
			rotary_dims_q <= DIMS_RESET;
			head_dims_q <= DIMS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PAIR_MODE: pair_mode_q <= cfg_data[0];
				CFG_ROTARY_DIMS: rotary_dims_q <= cfg_data;
				CFG_HEAD_DIMS: head_dims_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Element classification at the input transaction.
	// ------------------------------------------------------------------
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] head_eff, rot_eff, half_eff, idx, idx_next, pair_idx;
	logic             is_last;
	item_kind_t       kind;
	logic [POS_W-1:0] pos0, pos1;
	logic [AW-1:0]    hold_addr;
	logic [1:0]       n_new;
	logic             in_fire;

	always_comb begin
		head_eff = head_dims_q;
		if (head_dims_q > HEAD_LIM_C) begin
			head_eff = HEAD_LIM_C;
		end
		if (head_dims_q == '0) begin
			head_eff = CNT_W'(1);
		end
		rot_eff = (rotary_dims_q > head_eff) ? head_eff : rotary_dims_q;
		rot_eff[0] = 1'b0;
		half_eff = rot_eff >> 1;
		// A count left beyond the head width by a register change restarts.
		idx = (count_q >= head_eff) ? '0 : count_q;
		idx_next = idx + CNT_W'(1);
		is_last = (idx_next == head_eff);
		pair_idx = idx - half_eff;
		pos1 = POS_W'(idx);
		pos0 = POS_W'(idx);
		hold_addr = '0;
		if (idx >= rot_eff) begin
			kind = KIND_PASS;
		end else if (pair_mode_q == MODE_HALF) begin
			if (idx < half_eff) begin
				kind = KIND_HOLD;
				hold_addr = AW'(idx);
			end else begin
				kind = KIND_PAIR;
				hold_addr = AW'(pair_idx);
				pos0 = POS_W'(pair_idx);
			end
		end else begin
			// Interleave mode keeps its even element in entry zero.
			if (!idx[0]) begin
				kind = KIND_HOLD;
			end else begin
				kind = KIND_PAIR;
				pos0 = POS_W'(idx - CNT_W'(1));
			end
		end
		case (kind)
			KIND_PASS: n_new = 2'd1;
			KIND_PAIR: n_new = 2'd2;
			default: n_new = 2'd0;
		endcase
	end

	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_fire) begin
			count_q <= is_last ? '0 : idx_next;
		end
	end

	// ------------------------------------------------------------------
	// Hold memory. Held elements are written by one transaction and read
	// by a later one, so a read and a write never meet on the same edge.
	// ------------------------------------------------------------------
	hold_entry_t hold_mem [HOLD_DEPTH];
	hold_entry_t held_s1;

	always_ff @(posedge clk) begin
		if (in_fire && kind == KIND_HOLD) begin
			hold_mem[hold_addr] <= '{xv: x_value, cosv: cos_coef, sinv: sin_coef};
		end
		if (in_fire && kind == KIND_PAIR) begin
			held_s1 <= hold_mem[hold_addr];
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: the held element is available; form the four products.
	// ------------------------------------------------------------------
	logic                        valid_s1;
	item_kind_t                  kind_s1;
	logic                        mode_s1;
	logic signed [DATA_BITS-1:0] x_s1;
	logic signed [COEF_BITS-1:0] cos_s1, sin_s1;
	logic [POS_W-1:0]            pos0_s1, pos1_s1;
	logic                        last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire && kind != KIND_HOLD;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1 <= kind;
			mode_s1 <= pair_mode_q;
			x_s1 <= x_value;
			cos_s1 <= cos_coef;
			sin_s1 <= sin_coef;
			pos0_s1 <= pos0;
			pos1_s1 <= pos1;
			last_s1 <= is_last;
		end
	end

	// The second result uses the held coefficients in interleave mode and
	// the arriving ones in half mode.
	logic signed [COEF_BITS-1:0] cos1, sin1;
	assign cos1 = (mode_s1 == MODE_INTERLEAVE) ? held_s1.cosv : cos_s1;
	assign sin1 = (mode_s1 == MODE_INTERLEAVE) ? held_s1.sinv : sin_s1;

	// ------------------------------------------------------------------
	// Stage 2: products registered; sum, round and saturate into the queue.
	// ------------------------------------------------------------------
	logic                        valid_s2;
	item_kind_t                  kind_s2;
	logic signed [DATA_BITS-1:0] x_s2;
	logic signed [PW-1:0]        p0a_s2, p0b_s2, p1a_s2, p1b_s2;
	logic [POS_W-1:0]            pos0_s2, pos1_s2;
	logic                        last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			kind_s2 <= kind_s1;
			x_s2 <= x_s1;
			p0a_s2 <= held_s1.cosv * held_s1.xv;
			p0b_s2 <= held_s1.sinv * x_s1;
			p1a_s2 <= cos1 * x_s1;
			p1b_s2 <= sin1 * held_s1.xv;
			pos0_s2 <= pos0_s1;
			pos1_s2 <= pos1_s1;
			last_s2 <= last_s1;
		end
	end

	logic signed [DATA_BITS-1:0] rot0, rot1;
	logic [1:0]                  n_wr;
	assign rot0 = round_sat(SW'(p0a_s2) - SW'(p0b_s2));
	assign rot1 = round_sat(SW'(p1a_s2) + SW'(p1b_s2));
	assign n_wr = !valid_s2 ? 2'd0 : (kind_s2 == KIND_PAIR) ? 2'd2 : 2'd1;

	// ------------------------------------------------------------------
	// Result queue. The reservation count covers queued results and those
	// still in the pipeline, so a queue write always finds room.
	// ------------------------------------------------------------------
	result_t                 fifo_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [OUT_CNT_W-1:0]    fifo_cnt_q, committed_q;
	logic                    out_fire;

	assign out_valid = (fifo_cnt_q != '0);
	assign out_fire = out_valid && out_ready;
	assign in_ready = (committed_q <= OUT_CNT_W'(OUT_DEPTH - 2));

	assign out_position = fifo_q[rd_ptr_q].pos;
	assign out_value = fifo_q[rd_ptr_q].value;
	assign vector_end = fifo_q[rd_ptr_q].last;

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			if (kind_s2 == KIND_PAIR) begin
				fifo_q[wr_ptr_q] <= '{pos: pos0_s2, value: rot0, last: 1'b0};
				fifo_q[wr_ptr_q + OUT_PTR_W'(1)] <= '{pos: pos1_s2, value: rot1, last: last_s2};
			end else begin
				fifo_q[wr_ptr_q] <= '{pos: pos1_s2, value: x_s2, last: last_s2};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fifo_cnt_q <= '0;
			committed_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(n_wr);
			rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(out_fire);
			fifo_cnt_q <= fifo_cnt_q + OUT_CNT_W'(n_wr) - OUT_CNT_W'(out_fire);
			committed_q <= committed_q + OUT_CNT_W'(in_fire ? n_new : 2'd0)
				- OUT_CNT_W'(out_fire);
		end
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_reserve_bound: assert property (@(posedge clk) disable iff (!arst_n)
		committed_q <= OUT_CNT_W'(OUT_DEPTH))
		else $error("result reservations exceed the queue depth");

	a_queue_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= committed_q)
		else $error("queued results exceed their reservations");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ({1'b0, fifo_cnt_q} + {3'b000, n_wr}) <= (OUT_CNT_W + 1)'(OUT_DEPTH))
		else $error("queue write without room");

	a_pair_read: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && kind == KIND_PAIR) |=> (valid_s1 && kind_s1 == KIND_PAIR))
		else $error("paired element lost between classification and multiply");

endmodule
